[src/tmr_pkg.sv]
// shared types and constants of the timestamp match ring
package tmr_pkg;

  localparam int TMR_DEPTH = 8;

  localparam int SEC_W   = 32;
  localparam int FRAC_W  = 32;
  localparam int TIME_W  = 64;
  localparam int ENTRY_W = SEC_W + FRAC_W + TIME_W;

  // entry layout in memory: seconds, fraction, time (msb to lsb)
  localparam int TIME_LSB = 0;
  localparam int FRAC_LSB = TIME_W;
  localparam int SEC_LSB  = TIME_W + FRAC_W;

  typedef enum logic [1:0] {
    ACT_STASH   = 2'd0,
    ACT_CONSUME = 2'd1,
    ACT_SHIFT   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONSUME,
    ST_SHIFT
  } state_t;

endpackage

[src/timestamp_match_ring.sv]
// top level of the timestamp match ring: control, valid marks and entry memory
//
// a ring of DEPTH entries, each a 64-bit timestamp key (seconds, fraction) and
// a signed microsecond time, kept in one memory with a registered read port;
// the valid marks sit in flip-flops and are cleared by reset, the entries are
// undefined until a stash writes them. a transaction is taken when start is
// high and busy is low. a stash (or the unused action code) shows its result
// in the next cycle and busy stays low, so stashes may come back to back. a
// consume reads the entries one a cycle from index 0 and stops at the first
// valid match; a shift reads every entry, adds the delta to each valid one and
// writes it back. the entries are read one at a time through the single read
// port of the entry memory. every transaction gives exactly one result, shown
// on out_found and out_matched_wall_us for one cycle with out_strobe high; the
// receiver cannot stall it, so it must take it then
module timestamp_match_ring #(
  parameter int DEPTH = tmr_pkg::TMR_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_ts_seconds,
  input  logic [31:0]        in_ts_fraction,
  input  logic signed [63:0] in_wall_time_us,
  input  logic signed [63:0] in_delta_us,
  output logic               out_strobe,
  output logic               out_found,
  output logic signed [63:0] out_matched_wall_us
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // control state
  tmr_pkg::state_t state_r, state_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [IW-1:0]    wpos_r, wpos_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;     // entry whose read data is present

  // operands latched at accept
  logic [tmr_pkg::SEC_W-1:0]  key_sec_r, key_sec_nxt;
  logic [tmr_pkg::FRAC_W-1:0] key_frac_r, key_frac_nxt;
  logic [tmr_pkg::TIME_W-1:0] delta_r, delta_nxt;

  // result register
  logic                       strobe_r, strobe_nxt;
  logic                       found_r, found_nxt;
  logic [tmr_pkg::TIME_W-1:0] time_r, time_nxt;

  // memory ports
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [tmr_pkg::ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [tmr_pkg::ENTRY_W-1:0] ram_rdata;

  // fields of the entry being looked at
  logic [tmr_pkg::SEC_W-1:0]  rd_sec;
  logic [tmr_pkg::FRAC_W-1:0] rd_frac;
  logic [tmr_pkg::TIME_W-1:0] rd_time;
  logic                       hit;
  logic                       accept;

  tmr_ram #(
    .WIDTH (tmr_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_sec  = ram_rdata[tmr_pkg::SEC_LSB +: tmr_pkg::SEC_W];
  assign rd_frac = ram_rdata[tmr_pkg::FRAC_LSB +: tmr_pkg::FRAC_W];
  assign rd_time = ram_rdata[tmr_pkg::TIME_LSB +: tmr_pkg::TIME_W];

  // a valid entry whose key equals the latched key
  assign hit = valid_r[idx_r] && (rd_sec == key_sec_r) && (rd_frac == key_frac_r);

  assign busy   = (state_r != tmr_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tmr_pkg::ST_IDLE;
      valid_r  <= '0;
      wpos_r   <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      wpos_r   <= wpos_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
      found_r  <= found_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    key_sec_r  <= key_sec_nxt;
    key_frac_r <= key_frac_nxt;
    delta_r    <= delta_nxt;
    time_r     <= time_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    wpos_nxt     = wpos_r;
    idx_nxt      = idx_r;
    key_sec_nxt  = key_sec_r;
    key_frac_nxt = key_frac_r;
    delta_nxt    = delta_r;
    strobe_nxt   = 1'b0;
    found_nxt    = 1'b0;
    time_nxt     = '0;
    ram_we       = 1'b0;
    ram_waddr    = wpos_r;
    ram_wdata    = {in_ts_seconds, in_ts_fraction, in_wall_time_us};
    // scan reads run one entry ahead of the compare
    ram_raddr    = idx_r + IW'(1);

    case (state_r)
      tmr_pkg::ST_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          key_sec_nxt  = in_ts_seconds;
          key_frac_nxt = in_ts_fraction;
          delta_nxt    = in_delta_us;
          idx_nxt      = '0;
          case (tmr_pkg::action_t'(in_action))
            tmr_pkg::ACT_STASH: begin
              // overwrite the entry at the write position, old contents or not
              ram_we            = 1'b1;
              valid_nxt[wpos_r] = 1'b1;
              wpos_nxt          = (wpos_r == LAST_IDX) ? '0 : wpos_r + IW'(1);
              strobe_nxt        = 1'b1;
            end
            tmr_pkg::ACT_CONSUME: begin
              state_nxt = tmr_pkg::ST_CONSUME;
            end
            tmr_pkg::ACT_SHIFT: begin
              state_nxt = tmr_pkg::ST_SHIFT;
            end
            default: begin
              // unused code: empty result, no state change
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      tmr_pkg::ST_CONSUME: begin
        if (hit) begin
          // lowest matching index wins since the scan starts at zero
          valid_nxt[idx_r] = 1'b0;
          found_nxt        = 1'b1;
          time_nxt         = rd_time;
          strobe_nxt       = 1'b1;
          state_nxt        = tmr_pkg::ST_IDLE;
        end else if (idx_r == LAST_IDX) begin
          strobe_nxt = 1'b1;
          state_nxt  = tmr_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      tmr_pkg::ST_SHIFT: begin
        // write back entry idx_r while entry idx_r+1 is read, never the same
        ram_we    = valid_r[idx_r];
        ram_waddr = idx_r;
        ram_wdata = {rd_sec, rd_frac, rd_time + delta_r};
        if (idx_r == LAST_IDX) begin
          strobe_nxt = 1'b1;
          state_nxt  = tmr_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      default: begin
        state_nxt = tmr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_strobe          = strobe_r;
  assign out_found           = found_r;
  assign out_matched_wall_us = time_r;

`ifndef SYNTHESIS
  // a result only appears once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  // a stash leaves its entry valid
  a_stash_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == tmr_pkg::ACT_STASH) |=> valid_r[$past(wpos_r)])
    else $error("stashed entry not valid");

  // a consume hit clears the matched entry and reports found
  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmr_pkg::ST_CONSUME && hit) |=>
      (!valid_r[$past(idx_r)] && out_strobe && out_found))
    else $error("consume hit not retired");

  // a miss or a non-consume result carries zero time
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_matched_wall_us == '0))
    else $error("nonzero time without a match");
`endif

endmodule

[src/tmr_ram.sv]
// generic simple dual-port ram with registered read
module tmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[tb/timestamp_match_ring_tb.sv]
// self-checking testbench for the timestamp match ring: directed and random transactions
module timestamp_match_ring_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = tmr_pkg::TMR_DEPTH;
  localparam int RAND_CMDS   = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 12;

  // one stimulus transaction plus the idle cycles that go before it
  typedef struct {
    tmr_pkg::action_t   act;
    logic [31:0]        sec;
    logic [31:0]        frac;
    logic signed [63:0] wall;
    logic signed [63:0] delta;
    int                 gap;
    bit                 drain;
  } ring_cmd_t;

  // what one transaction reports back
  typedef struct {
    logic               found;
    logic signed [63:0] wall;
  } ring_hit_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [31:0] frac;
  } ts_key_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_action = '0;
  logic [31:0]        in_ts_seconds = '0;
  logic [31:0]        in_ts_fraction = '0;
  logic signed [63:0] in_wall_time_us = '0;
  logic signed [63:0] in_delta_us = '0;
  logic               out_strobe;
  logic               out_found;
  logic signed [63:0] out_matched_wall_us;

  timestamp_match_ring #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_ts_seconds      (in_ts_seconds),
    .in_ts_fraction     (in_ts_fraction),
    .in_wall_time_us    (in_wall_time_us),
    .in_delta_us        (in_delta_us),
    .out_strobe         (out_strobe),
    .out_found          (out_found),
    .out_matched_wall_us(out_matched_wall_us)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the ring, updated once per accepted transaction
  // ---------------------------------------------------------------------------
  logic [31:0]        slot_sec  [RING_DEPTH];
  logic [31:0]        slot_frac [RING_DEPTH];
  logic signed [63:0] slot_us   [RING_DEPTH];
  bit                 slot_live [RING_DEPTH];
  int                 wr_slot = 0;

  ring_cmd_t cmd_backlog[$];   // transactions not yet driven
  ring_hit_t hit_forecast[$];  // results still owed by the block
  int        fault_cnt = 0;

  // applies one transaction to the shadow ring and returns its result
  function automatic ring_hit_t ring_apply(input ring_cmd_t c);
    ring_hit_t r;
    int        i;
    r.found = 1'b0;
    r.wall  = '0;
    case (c.act)
      tmr_pkg::ACT_STASH: begin
        slot_sec[wr_slot]  = c.sec;
        slot_frac[wr_slot] = c.frac;
        slot_us[wr_slot]   = c.wall;
        slot_live[wr_slot] = 1'b1;
        wr_slot = (wr_slot + 1) % RING_DEPTH;
      end
      tmr_pkg::ACT_CONSUME: begin
        // lowest matching index wins and is the only one cleared
        for (i = 0; i < RING_DEPTH; i++) begin
          if (!r.found && slot_live[i] && slot_sec[i] == c.sec && slot_frac[i] == c.frac) begin
            r.found      = 1'b1;
            r.wall       = slot_us[i];
            slot_live[i] = 1'b0;
          end
        end
      end
      tmr_pkg::ACT_SHIFT: begin
        // wraps modulo 2^64 by the width of the vectors
        for (i = 0; i < RING_DEPTH; i++) begin
          if (slot_live[i]) slot_us[i] = slot_us[i] + c.delta;
        end
      end
      default: ;  // unused code leaves the ring alone
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  bit      calm_stretch = 1'b0;
  ts_key_t key_pool[POOL_SIZE];
  ts_key_t recent_keys[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm_stretch) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] pick_time();
    case ($urandom_range(19))
      0: return 64'sh7FFF_FFFF_FFFF_FFFF;
      1: return 64'sh8000_0000_0000_0000;
      2: return 64'sd0;
      3: return -64'sd1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic signed [63:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $signed(64'($urandom_range(2000))) - 64'sd1000;
    if (r < 35) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (r < 40) return 64'sh8000_0000_0000_0000;
    return rand64();
  endfunction

  // key for a new entry: usually from a small pool so that duplicates occur
  function automatic ts_key_t pick_key();
    ts_key_t k;
    if ($urandom_range(99) < 60) begin
      k = key_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      k.sec  = $urandom;
      k.frac = $urandom;
    end
    return k;
  endfunction

  task automatic queue_cmd(input tmr_pkg::action_t a, input logic [31:0] s,
                           input logic [31:0] f,
                           input logic signed [63:0] w, input logic signed [63:0] d,
                           input bit drain);
    ring_cmd_t c;
    c.act   = a;
    c.sec   = s;
    c.frac  = f;
    c.wall  = w;
    c.delta = d;
    c.gap   = pick_gap();
    c.drain = drain;
    cmd_backlog.push_back(c);
  endtask

  initial begin
    int      counted;
    int      r;
    ts_key_t k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i].sec  = (i < 2) ? 32'h0 : $urandom;
      key_pool[i].frac = (i == 1) ? 32'hFFFF_FFFF : $urandom;
    end

    // directed part: fill every slot first so no unwritten entry is ever scanned
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_0000, 32'h0000_0000, 64'sd0, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              64'sh7FFF_FFFF_FFFF_FFFF, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'hFFFF_FFFF, 32'h0000_0000,
              64'sh8000_0000_0000_0000, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_0000, 32'hFFFF_FFFF, -64'sd1, rand64(), 1'b0);
    // two entries with the same key
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_000A, 32'h0000_000B, 64'sd5, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_000A, 32'h0000_000B, 64'sd6, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_0001, 32'h0000_0002, 64'sd100, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_0003, 32'h0000_0004, 64'sd200, rand64(), 1'b0);
    // shift by one: the largest time wraps to the most negative
    queue_cmd(tmr_pkg::ACT_SHIFT, $urandom, $urandom, rand64(), 64'sd1, 1'b1);
    // duplicates come out lowest index first, then the key misses
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_000A, 32'h0000_000B, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_000A, 32'h0000_000B, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_000A, 32'h0000_000B, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_SHIFT, $urandom, $urandom, rand64(),
              64'sh8000_0000_0000_0000, 1'b0);
    queue_cmd(tmr_pkg::ACT_NONE, $urandom, $urandom, rand64(), rand64(), 1'b0);
    // write position wrapped: this overwrites the still valid zero key
    queue_cmd(tmr_pkg::ACT_STASH, 32'h0000_0005, 32'h0000_0006, 64'sd7, rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0000, 32'h0000_0000, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0005, 32'h0000_0006, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'hFFFF_FFFF, 32'h0000_0000, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0000, 32'hFFFF_FFFF, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0001, 32'h0000_0002, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0003, 32'h0000_0004, rand64(), rand64(), 1'b0);
    // ring is now empty
    queue_cmd(tmr_pkg::ACT_CONSUME, 32'h0000_0001, 32'h0000_0002, rand64(), rand64(), 1'b0);
    queue_cmd(tmr_pkg::ACT_SHIFT, $urandom, $urandom, rand64(),
              64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);

    // random part: mostly stash/consume pairs on shared keys, some shifts and noise
    counted = 0;
    while (counted < RAND_CMDS) begin
      calm_stretch = ((counted / 150) % 4) == 3;
      r = $urandom_range(99);
      if (r < 3) begin
        // ignored code, not counted
        queue_cmd(tmr_pkg::ACT_NONE, $urandom, $urandom, rand64(), rand64(), 1'b0);
      end else begin
        counted++;
        if (r < 45) begin
          k = pick_key();
          recent_keys.push_back(k);
          if (recent_keys.size() > RING_DEPTH) void'(recent_keys.pop_front());
          queue_cmd(tmr_pkg::ACT_STASH, k.sec, k.frac, pick_time(), rand64(),
                    $urandom_range(99) == 0);
        end else if (r < 85) begin
          r = $urandom_range(99);
          if (r < 65 && recent_keys.size() > 0) begin
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
          end else if (r < 80) begin
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
          end else begin
            k.sec  = $urandom;
            k.frac = $urandom;
          end
          queue_cmd(tmr_pkg::ACT_CONSUME, k.sec, k.frac, rand64(), rand64(),
                    $urandom_range(99) == 0);
        end else begin
          queue_cmd(tmr_pkg::ACT_SHIFT, $urandom, $urandom, rand64(), pick_delta(),
                    $urandom_range(99) == 0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reset: held from the start, released once
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < RING_DEPTH; i++) slot_live[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sampled mid-cycle so the driver can read it without racing the monitor
  bit ring_drained = 1'b1;
  always @(negedge clk) begin
    ring_drained <= (hit_forecast.size() == 0);
  end

  // ---------------------------------------------------------------------------
  // driver: start stays high until the block takes the transaction
  // ---------------------------------------------------------------------------
  ring_cmd_t next_cmd;
  bit        cmd_live = 1'b0;   // start is high with next_cmd on the ports
  bit        have_next = 1'b0;  // next_cmd popped but not yet driven
  bit        took;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = 1'b0;
      if (cmd_live && !busy) begin
        // accepted at this edge: forecast its result now
        hit_forecast.push_back(ring_apply(next_cmd));
        cmd_live = 1'b0;
        took     = 1'b1;
      end
      if (!cmd_live && !have_next && cmd_backlog.size() > 0) begin
        next_cmd  = cmd_backlog.pop_front();
        have_next = 1'b1;
        gap_left  = next_cmd.gap;
      end
      if (!cmd_live && have_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!next_cmd.drain || (!took && ring_drained)) begin
          // a drain transaction waits until every owed result has come back
          in_action       <= next_cmd.act;
          in_ts_seconds   <= next_cmd.sec;
          in_ts_fraction  <= next_cmd.frac;
          in_wall_time_us <= next_cmd.wall;
          in_delta_us     <= next_cmd.delta;
          cmd_live  = 1'b1;
          have_next = 1'b0;
        end
      end
      start <= cmd_live;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is matched against the oldest forecast
  // ---------------------------------------------------------------------------
  ring_hit_t want;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (hit_forecast.size() == 0) begin
        $display("%0t: result with none pending, found %0b wall %0d", $time, out_found,
                 out_matched_wall_us);
        fault_cnt++;
      end else begin
        want = hit_forecast.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_found);
          fault_cnt++;
        end
        if (out_matched_wall_us !== want.wall) begin
          $display("%0t: matched_wall_us expected %0d actual %0d", $time, want.wall,
                   out_matched_wall_us);
          fault_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run watchdog
  // ---------------------------------------------------------------------------
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timestamp_match_ring: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // end of run: drain everything, allow the longest scan to finish, then judge
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    while (cmd_backlog.size() > 0 || have_next || cmd_live || hit_forecast.size() > 0)
      @(negedge clk);
    repeat (2 * RING_DEPTH + 4) @(negedge clk);
    if (hit_forecast.size() > 0)
      $display("%0t: %0d results never arrived", $time, hit_forecast.size());
    if (fault_cnt == 0 && hit_forecast.size() == 0) begin
      $display("timestamp_match_ring: match");
    end else begin
      $display("timestamp_match_ring: mismatch");
    end
    $finish;
  end

endmodule
